// ----- rtl/core/adampu_pkg.sv -----
// shared types, constants and the divide step of the parameter update block
`timescale 1ns / 1ps
package adampu_pkg;

  // moment store geometry
  localparam int NUM_PARAMS = 1024;
  localparam int IDX_W      = 10;

  // item kinds
  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // register map, word index
  localparam logic [1:0] REG_LEARNING_RATE  = 2'd0;
  localparam logic [1:0] REG_FIRST_DECAY    = 2'd1;
  localparam logic [1:0] REG_SECOND_DECAY   = 2'd2;
  localparam logic [1:0] REG_STABILITY_TERM = 2'd3;

  // register reset values
  localparam logic [15:0] RST_LEARNING_RATE  = 16'd66;
  localparam logic [15:0] RST_FIRST_DECAY    = 16'd58982;
  localparam logic [15:0] RST_SECOND_DECAY   = 16'd65470;
  localparam logic [15:0] RST_STABILITY_TERM = 16'd1;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] gradient_value;
    logic               pass_end;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_index;
    logic signed [31:0] new_value;
    logic               clipped;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] first_decay;
    logic [15:0] second_decay;
    logic [15:0] stability_term;
  } cfg_t;

  // updated moments leaving the memory stage
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic signed [31:0] m;
    logic [63:0]        v;
    logic [32:0]        den1;
    logic [32:0]        den2;
  } mom_beat_t;

  // corrected first moment and root of corrected second moment
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic               neg;
    logic [47:0]        mh;
    logic [31:0]        root;
  } root_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } tail_beat_t;

  // restoring divider state: partial remainder and shifting dividend/quotient
  typedef struct packed {
    logic [32:0] rem;
    logic [63:0] work;
  } div_state_t;

  // one quotient bit per call
  function automatic div_state_t div_step(div_state_t s, logic [32:0] den);
    div_state_t  o;
    logic [33:0] t;
    logic [33:0] d;
    t = {s.rem, s.work[63]};
    d = {1'b0, den};
    if (t >= d) begin
      o.rem  = 33'(t - d);
      o.work = {s.work[62:0], 1'b1};
    end else begin
      o.rem  = t[32:0];
      o.work = {s.work[62:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/adam_parameter_update.sv -----
// Adam parameter update: one update beat in per cycle, one result beat out per update.
// A beat is taken every cycle unless the output skid stage is full; an update's result
// passes through the moment stages, the 64-step bias correction dividers, the 32-step
// square root and the 33-step step divider, each retiring one bit per stage. First and
// second moments live in two 1024-entry synchronous memories updated read-modify-write
// with forwarding, so updates to the same parameter may follow each other in adjacent
// cycles. A restart beat and an out-of-range index produce no result. Moment entries
// hold no reset value: after the first pass an entry must have been written before it
// is read. Configuration registers (APB, word addresses 0x0 learning rate, 0x4 beta1,
// 0x8 beta2, 0xC epsilon) should be written only while no update is in flight; beta
// writes feed the moment update and the decay power products at once, not only at restart.
`timescale 1ns / 1ps
module adam_parameter_update (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  adampu_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output adampu_pkg::out_beat_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import adampu_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic       en;
  logic       in_fire;
  mom_beat_t  mom;
  root_beat_t root;
  tail_beat_t tail;
  logic       out_vld_r, out_vld_nxt;
  out_beat_t  out_r, out_nxt;
  logic       skid_vld_r, skid_vld_nxt;
  out_beat_t  skid_r, skid_nxt;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LEARNING_RATE:  cfg_nxt.learning_rate  = pwdata[15:0];
        REG_FIRST_DECAY:    cfg_nxt.first_decay    = pwdata[15:0];
        REG_SECOND_DECAY:   cfg_nxt.second_decay   = pwdata[15:0];
        REG_STABILITY_TERM: cfg_nxt.stability_term = pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate  <= RST_LEARNING_RATE;
      cfg_r.first_decay    <= RST_FIRST_DECAY;
      cfg_r.second_decay   <= RST_SECOND_DECAY;
      cfg_r.stability_term <= RST_STABILITY_TERM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_LEARNING_RATE:  prdata = {16'd0, cfg_r.learning_rate};
      REG_FIRST_DECAY:    prdata = {16'd0, cfg_r.first_decay};
      REG_SECOND_DECAY:   prdata = {16'd0, cfg_r.second_decay};
      REG_STABILITY_TERM: prdata = {16'd0, cfg_r.stability_term};
    endcase
  end

  // pipeline advances whenever the skid stage is free
  assign en       = !skid_vld_r;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  adampu_moment u_moment (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_fire (in_fire),
    .in_data (in_data),
    .cfg     (cfg_r),
    .mom     (mom)
  );

  adampu_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .mom   (mom),
    .root  (root)
  );

  adampu_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .root  (root),
    .cfg   (cfg_r),
    .tail  (tail)
  );

  // output register with skid stage
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    priority if (skid_vld_r) begin
      if (out_ready) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (tail.valid) begin
      if (!out_vld_r || out_ready) begin
        out_nxt     = tail.beat;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = tail.beat;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/adampu_ram.sv -----
// simple dual port synchronous ram, registered read
`timescale 1ns / 1ps
module adampu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/adampu_moment.sv -----
// moment memories, read-modify-write with forwarding, decay powers
`timescale 1ns / 1ps
module adampu_moment (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_fire,
  input  adampu_pkg::in_beat_t  in_data,
  input  adampu_pkg::cfg_t      cfg,
  output adampu_pkg::mom_beat_t mom
);
  import adampu_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic signed [31:0] g;
    logic [63:0]        g2;
    logic [32:0]        den1;
    logic [32:0]        den2;
    logic               fp;
  } s1_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic signed [31:0] m;
    logic [63:0]        v;
    logic [32:0]        den1;
    logic [32:0]        den2;
  } s2_t;

  logic               take;
  logic               restart;
  logic [31:0]        pw1_r, pw1_nxt, pw2_r, pw2_nxt;
  logic               fp_r, fp_nxt;
  logic [47:0]        pw1_prod, pw2_prod;
  logic [31:0]        gmag;
  logic [63:0]        g2;
  logic               s1_vld_r;
  s1_t                s1_r;
  logic               s2_vld_r;
  s2_t                s2_r;
  logic               fwd_hit_r;
  logic [31:0]        fwd_m_r;
  logic [63:0]        fwd_v_r;
  logic [31:0]        ram_m;
  logic [63:0]        ram_v;
  logic signed [31:0] m_old;
  logic [63:0]        v_old;
  logic [16:0]        b1c, b2c;
  logic signed [50:0] m_acc;
  logic [33:0]        v_lo;
  logic [65:0]        v_acc;
  logic [31:0]        m_new;
  logic [63:0]        v_new;

  // item decode
  assign take    = in_fire && (in_data.kind == KIND_UPDATE)
                   && (int'(in_data.param_index) < NUM_PARAMS);
  assign restart = in_fire && (in_data.kind == KIND_RESTART);

  // decay powers and first pass flag
  assign pw1_prod = pw1_r * cfg.first_decay;
  assign pw2_prod = pw2_r * cfg.second_decay;

  always_comb begin
    pw1_nxt = pw1_r;
    pw2_nxt = pw2_r;
    fp_nxt  = fp_r;
    priority if (restart) begin
      pw1_nxt = {cfg.first_decay, 16'd0};
      pw2_nxt = {cfg.second_decay, 16'd0};
      fp_nxt  = 1'b1;
    end else if (take && in_data.pass_end) begin
      pw1_nxt = pw1_prod[47:16];
      pw2_nxt = pw2_prod[47:16];
      fp_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw1_r <= {RST_FIRST_DECAY, 16'd0};
      pw2_r <= {RST_SECOND_DECAY, 16'd0};
      fp_r  <= 1'b1;
    end else begin
      pw1_r <= pw1_nxt;
      pw2_r <= pw2_nxt;
      fp_r  <= fp_nxt;
    end
  end

  // squared gradient ahead of the moment stage
  assign gmag = in_data.gradient_value[31] ? (~in_data.gradient_value + 32'd1)
                                           : in_data.gradient_value;
  assign g2   = gmag * gmag;

  // moment memories
  adampu_ram #(.DEPTH(NUM_PARAMS), .WIDTH(32), .AW(IDX_W)) u_first (
    .clk     (clk),
    .wr_en   (en && s1_vld_r),
    .wr_addr (s1_r.idx),
    .wr_data (m_new),
    .rd_en   (en),
    .rd_addr (in_data.param_index),
    .rd_data (ram_m)
  );

  adampu_ram #(.DEPTH(NUM_PARAMS), .WIDTH(64), .AW(IDX_W)) u_second (
    .clk     (clk),
    .wr_en   (en && s1_vld_r),
    .wr_addr (s1_r.idx),
    .wr_data (v_new),
    .rd_en   (en),
    .rd_addr (in_data.param_index),
    .rd_data (ram_v)
  );

  // old moments: zero in first pass, forwarded on back to back same index
  always_comb begin
    priority if (s1_r.fp) begin
      m_old = '0;
      v_old = '0;
    end else if (fwd_hit_r) begin
      m_old = fwd_m_r;
      v_old = fwd_v_r;
    end else begin
      m_old = ram_m;
      v_old = ram_v;
    end
  end

  // moment update, rounded weighted averages
  assign b1c   = 17'h10000 - {1'b0, cfg.first_decay};
  assign b2c   = 17'h10000 - {1'b0, cfg.second_decay};
  assign m_acc = $signed({1'b0, cfg.first_decay}) * m_old
               + $signed({1'b0, b1c}) * s1_r.g + 51'sd32768;
  assign m_new = m_acc[47:16];
  assign v_lo  = cfg.second_decay * v_old[15:0] + b2c * s1_r.g2[15:0] + 34'd32768;
  assign v_acc = cfg.second_decay * v_old[63:16] + b2c * s1_r.g2[63:16]
               + 66'(v_lo[33:16]);
  assign v_new = v_acc[63:0];

  // stage valids and forward flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= take;
      s2_vld_r  <= s1_vld_r;
      fwd_hit_r <= s1_vld_r && (s1_r.idx == in_data.param_index);
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.idx  <= in_data.param_index;
      s1_r.p    <= in_data.param_value;
      s1_r.g    <= in_data.gradient_value;
      s1_r.g2   <= g2;
      s1_r.den1 <= 33'h1_0000_0000 - {1'b0, pw1_r};
      s1_r.den2 <= 33'h1_0000_0000 - {1'b0, pw2_r};
      s1_r.fp   <= fp_r;
      fwd_m_r   <= m_new;
      fwd_v_r   <= v_new;
      s2_r.idx  <= s1_r.idx;
      s2_r.p    <= s1_r.p;
      s2_r.m    <= m_new;
      s2_r.v    <= v_new;
      s2_r.den1 <= s1_r.den1;
      s2_r.den2 <= s1_r.den2;
    end
  end

  always_comb begin
    mom.valid = s2_vld_r;
    mom.idx   = s2_r.idx;
    mom.p     = s2_r.p;
    mom.m     = s2_r.m;
    mom.v     = s2_r.v;
    mom.den1  = s2_r.den1;
    mom.den2  = s2_r.den2;
  end

endmodule

// ----- rtl/core/adampu_scale.sv -----
// bias correction dividers and square root pipeline
`timescale 1ns / 1ps
module adampu_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  adampu_pkg::mom_beat_t  mom,
  output adampu_pkg::root_beat_t root
);
  import adampu_pkg::*;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sqrt_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic               neg;
    logic               sat;
    logic [32:0]        den_a;
    logic [32:0]        den_b;
    div_state_t         a;
    div_state_t         b;
  } dv_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic               neg;
    logic [47:0]        mh;
    sqrt_state_t        s;
  } sq_t;

  // one root bit per call
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [63:0] b);
    sqrt_state_t o;
    logic [63:0] trial;
    trial = s.r + b;
    if (s.x >= trial) begin
      o.x = s.x - trial;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // both lanes advance one quotient bit
  function automatic dv_t dv_adv(dv_t d);
    dv_t o;
    o   = d;
    o.a = div_step(d.a, d.den_a);
    o.b = div_step(d.b, d.den_b);
    return o;
  endfunction

  function automatic sq_t sq_adv(sq_t q, int k);
    sq_t o;
    o   = q;
    o.s = sqrt_step(q.s, 64'd1 << (62 - 2 * k));
    return o;
  endfunction

  logic                  ld_vld_r;
  dv_t                   ld_r;
  logic [DIV_STEPS-1:0]  dv_vld_r;
  dv_t                   dv_r [DIV_STEPS];
  logic [SQRT_STEPS-1:0] sq_vld_r;
  sq_t                   sq_r [SQRT_STEPS];
  logic [31:0]           mmag;
  logic                  vsat;
  sq_t                   sq_init;

  // divider load terms; corrected second moment saturates when quotient tops 64 bits
  assign mmag = mom.m[31] ? (~mom.m + 32'd1) : mom.m;
  assign vsat = {1'b0, mom.v[63:32]} >= mom.den2;

  always_comb begin
    sq_init.idx = dv_r[DIV_STEPS-1].idx;
    sq_init.p   = dv_r[DIV_STEPS-1].p;
    sq_init.neg = dv_r[DIV_STEPS-1].neg;
    sq_init.mh  = dv_r[DIV_STEPS-1].a.work[47:0];
    sq_init.s.x = dv_r[DIV_STEPS-1].sat ? '1 : dv_r[DIV_STEPS-1].b.work;
    sq_init.s.r = '0;
  end

  // valid shift chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= 1'b0;
      dv_vld_r <= '0;
      sq_vld_r <= '0;
    end else if (en) begin
      ld_vld_r <= mom.valid;
      dv_vld_r <= {dv_vld_r[DIV_STEPS-2:0], ld_vld_r};
      sq_vld_r <= {sq_vld_r[SQRT_STEPS-2:0], dv_vld_r[DIV_STEPS-1]};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      ld_r.idx    <= mom.idx;
      ld_r.p      <= mom.p;
      ld_r.neg    <= mom.m[31];
      ld_r.sat    <= vsat;
      ld_r.den_a  <= mom.den1;
      ld_r.den_b  <= mom.den2;
      ld_r.a.rem  <= '0;
      ld_r.a.work <= {mmag, 32'd0};
      ld_r.b.rem  <= vsat ? '0 : {1'b0, mom.v[63:32]};
      ld_r.b.work <= {mom.v[31:0], 32'd0};
      dv_r[0]     <= dv_adv(ld_r);
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_r[k] <= dv_adv(dv_r[k-1]);
      end
      sq_r[0] <= sq_adv(sq_init, 0);
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_r[k] <= sq_adv(sq_r[k-1], k);
      end
    end
  end

  always_comb begin
    root.valid = sq_vld_r[SQRT_STEPS-1];
    root.idx   = sq_r[SQRT_STEPS-1].idx;
    root.p     = sq_r[SQRT_STEPS-1].p;
    root.neg   = sq_r[SQRT_STEPS-1].neg;
    root.mh    = sq_r[SQRT_STEPS-1].mh;
    root.root  = sq_r[SQRT_STEPS-1].s.r[31:0];
  end

endmodule

// ----- rtl/core/adampu_step.sv -----
// step size product, step divider and saturating parameter update
`timescale 1ns / 1ps
module adampu_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  adampu_pkg::root_beat_t root,
  input  adampu_pkg::cfg_t       cfg,
  output adampu_pkg::tail_beat_t tail
);
  import adampu_pkg::*;

  localparam int DIV_STEPS = 33;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic               neg;
    logic [32:0]        den;
    logic [63:0]        prod;
  } pr_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic               neg;
    logic               sat;
    logic [32:0]        den;
    div_state_t         st;
  } dq_t;

  function automatic dq_t dq_adv(dq_t d);
    dq_t o;
    o    = d;
    o.st = div_step(d.st, d.den);
    return o;
  endfunction

  logic                 pr_vld_r;
  pr_t                  pr_r;
  logic                 ld_vld_r;
  dq_t                  ld_r;
  logic [DIV_STEPS-1:0] dv_vld_r;
  dq_t                  dv_r [DIV_STEPS];
  logic                 tl_vld_r;
  out_beat_t            tl_r;
  logic [32:0]          den_sum;
  logic [32:0]          den_fix;
  logic [63:0]          prod;
  logic                 d_sat;
  logic [33:0]          stepv;
  logic signed [35:0]   p_ext;
  logic signed [35:0]   s_ext;
  logic signed [35:0]   nv;
  logic                 clip_hi;
  logic                 clip_lo;
  out_beat_t            res;

  // denominator, zero taken as one, and scaled numerator
  assign den_sum = {1'b0, root.root} + {17'd0, cfg.stability_term};
  assign den_fix = (den_sum == '0) ? 33'd1 : den_sum;
  assign prod    = root.mh * cfg.learning_rate;

  // step capped at 2^33 when the high dividend part reaches the divisor
  assign d_sat = {2'b0, pr_r.prod[63:33]} >= pr_r.den;

  // apply step against the sign of the moment, saturate to 32 bits
  always_comb begin
    dq_t last;
    last    = dv_r[DIV_STEPS-1];
    stepv   = last.sat ? 34'h2_0000_0000 : {1'b0, last.st.work[32:0]};
    p_ext   = {{4{last.p[31]}}, last.p};
    s_ext   = {2'b0, stepv};
    nv      = last.neg ? (p_ext + s_ext) : (p_ext - s_ext);
    clip_hi = !nv[35] && (nv[34:31] != 4'h0);
    clip_lo = nv[35] && (nv[34:31] != 4'hF);
    res.result_index = last.idx;
    res.clipped      = clip_hi || clip_lo;
    priority if (clip_hi) begin
      res.new_value = 32'sh7FFF_FFFF;
    end else if (clip_lo) begin
      res.new_value = 32'sh8000_0000;
    end else begin
      res.new_value = nv[31:0];
    end
  end

  // valid shift chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
      ld_vld_r <= 1'b0;
      dv_vld_r <= '0;
      tl_vld_r <= 1'b0;
    end else if (en) begin
      pr_vld_r <= root.valid;
      ld_vld_r <= pr_vld_r;
      dv_vld_r <= {dv_vld_r[DIV_STEPS-2:0], ld_vld_r};
      tl_vld_r <= dv_vld_r[DIV_STEPS-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r.idx     <= root.idx;
      pr_r.p       <= root.p;
      pr_r.neg     <= root.neg;
      pr_r.den     <= den_fix;
      pr_r.prod    <= prod;
      ld_r.idx     <= pr_r.idx;
      ld_r.p       <= pr_r.p;
      ld_r.neg     <= pr_r.neg;
      ld_r.sat     <= d_sat;
      ld_r.den     <= pr_r.den;
      ld_r.st.rem  <= d_sat ? '0 : {2'b0, pr_r.prod[63:33]};
      ld_r.st.work <= {pr_r.prod[32:0], 31'd0};
      dv_r[0]      <= dq_adv(ld_r);
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_r[k] <= dq_adv(dv_r[k-1]);
      end
      tl_r <= res;
    end
  end

  assign tail.valid = tl_vld_r;
  assign tail.beat  = tl_r;

endmodule

// ----- rtl/core/adampu_chk.sv -----
// port level checks for the parameter update block and their binding
`timescale 1ns / 1ps
module adampu_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input adampu_pkg::out_beat_t out_data,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [3:0]            paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata
);

  // a stalled result beat stays offered unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // input back-pressure only follows a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // a written register reads back its low half
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite ##1 paddr == $past(paddr)
      |-> prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'd0)
    else $error("register readback mismatch");

endmodule

bind adam_parameter_update adampu_chk u_adampu_chk (.*);
